// ===== rtl/ptt_pkg.sv =====
// ----------------------------------------------------------------------------
// ptt_pkg
// operation codes, register indexes and constants of the pair tabu table
// ----------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

   localparam int OP_BITS = 3;
   localparam int VALUE_BITS = 32;
   localparam int TENURE_BITS = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [OP_BITS-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_BITS-1:0] OP_ADD    = 3'd1;
   localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_BITS-1:0] OP_MOVE   = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CHECK  = 3'd4;
   localparam logic [OP_BITS-1:0] OP_SCAN   = 3'd5;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_TENURE     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ASPIRATION = 2'd1;

   localparam logic [TENURE_BITS-1:0] TENURE_RESET = 16'd7;

   // -1.0 in signed Q16.16
   localparam logic signed [VALUE_BITS-1:0] VALUE_MINUS_ONE = 32'shFFFF_0000;

   localparam logic RESULT_CHECK = 1'b0;
   localparam logic RESULT_SCAN  = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/pair_tabu_table.sv =====
// ----------------------------------------------------------------------------
// pair_tabu_table
// tabu list over item/group pairs with iteration stamps and aspiration values
// a check or final scan result passes the stage register and then the result register
// throughput: one item per cycle unless held by a clear, a waiting result or a move write
// after reset and after the iteration counter wraps, a clearing pass over all
// ITEMS*GROUPS cells resets every valid mark; no item is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module pair_tabu_table #(
   parameter int ITEMS = 64,
   parameter int GROUPS = 16,
   parameter int STAMP_BITS = 31,
   localparam int ITEM_BITS = (ITEMS > 1) ? $clog2(ITEMS) : 1,
   localparam int GROUP_BITS = (GROUPS > 1) ? $clog2(GROUPS) : 1
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         csr_wr_en,
   input  wire logic [ptt_pkg::CSR_INDEX_BITS-1:0]           csr_index,
   input  wire logic [ptt_pkg::TENURE_BITS-1:0]              csr_wdata,
   input  wire logic                                         req_valid,
   output logic                                              req_ready,
   input  wire logic [ptt_pkg::OP_BITS-1:0]                  req_operation,
   input  wire logic [ITEM_BITS-1:0]                         req_item_index,
   input  wire logic [GROUP_BITS-1:0]                        req_group_index,
   input  wire logic [GROUP_BITS-1:0]                        req_other_group,
   input  wire logic signed [ptt_pkg::VALUE_BITS-1:0]        req_value,
   input  wire logic                                         req_last,
   output logic                                              rsp_valid,
   input  wire logic                                         rsp_ready,
   output logic                                              rsp_result_kind,
   output logic                                              rsp_tabu,
   output logic                                              rsp_allowed,
   output logic                                              rsp_reassignable
);

   localparam int CELLS = ITEMS * GROUPS;
   localparam int CELL_BITS = $clog2(CELLS);
   localparam int SUM_BITS = ((STAMP_BITS > ptt_pkg::TENURE_BITS) ?
                              STAMP_BITS : ptt_pkg::TENURE_BITS) + 1;
   localparam int VB = ptt_pkg::VALUE_BITS;

   function automatic logic in_range(input logic [ITEM_BITS-1:0] item,
                                     input logic [GROUP_BITS-1:0] group);
      in_range = ({1'b0, item} < (ITEM_BITS+1)'(ITEMS)) &&
                 ({1'b0, group} < (GROUP_BITS+1)'(GROUPS));
   endfunction

   function automatic logic [CELL_BITS-1:0] cell_of(input logic [ITEM_BITS-1:0] item,
                                                    input logic [GROUP_BITS-1:0] group);
      cell_of = CELL_BITS'(CELL_BITS'(item) * CELL_BITS'(GROUPS) + CELL_BITS'(group));
   endfunction

   // configuration
   logic [ptt_pkg::TENURE_BITS-1:0] tenure_ff;
   logic                            aspiration_ff;

   // table storage: {valid, stamp} and aspiration value
   logic [STAMP_BITS:0]   stamp_mem_ff [CELLS];
   logic signed [VB-1:0]  value_mem_ff [CELLS];
   logic [STAMP_BITS:0]   rd_stamp_ff;
   logic signed [VB-1:0]  rd_value_ff;

   // control state
   logic [STAMP_BITS-1:0] count_ff, count_in;
   logic                  clr_busy_ff, clr_busy_in;
   logic [CELL_BITS-1:0]  clr_cnt_ff, clr_cnt_in;
   logic                  scan_found_ff, scan_found_in;

   // stage register
   logic                             stage_valid_ff, stage_valid_in;
   logic [ptt_pkg::OP_BITS-1:0]      stage_op_ff;
   logic [ITEM_BITS-1:0]             stage_item_ff;
   logic [GROUP_BITS-1:0]            stage_group_ff;
   logic [GROUP_BITS-1:0]            stage_other_ff;
   logic signed [VB-1:0]             stage_value_ff;
   logic                             stage_last_ff;

   // result register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_kind_ff, rsp_kind_in;
   logic rsp_tabu_ff, rsp_tabu_in;
   logic rsp_allowed_ff, rsp_allowed_in;
   logic rsp_reassign_ff, rsp_reassign_in;

   logic req_fire;
   logic req_ok;
   logic [CELL_BITS-1:0] req_cell;
   logic stage_ok;
   logic other_ok;
   logic [CELL_BITS-1:0] other_cell;
   logic move_busy;
   logic emits;
   logic stage_stall;
   logic rsp_free;
   logic wrap;
   logic [SUM_BITS-1:0] limit;
   logic tabu;
   logic allowed;
   logic hit;

   logic                  st_we;
   logic [CELL_BITS-1:0]  st_addr;
   logic [STAMP_BITS:0]   st_data;
   logic                  va_we;
   logic [CELL_BITS-1:0]  va_addr;
   logic signed [VB-1:0]  va_data;

   assign req_ok     = in_range(req_item_index, req_group_index);
   assign req_cell   = cell_of(req_item_index, req_group_index);
   assign stage_ok   = in_range(stage_item_ff, stage_group_ff);
   assign other_ok   = in_range(stage_item_ff, stage_other_ff);
   assign other_cell = cell_of(stage_item_ff, stage_other_ff);

   assign move_busy   = stage_valid_ff && (stage_op_ff == ptt_pkg::OP_MOVE);
   assign emits       = stage_valid_ff && ((stage_op_ff == ptt_pkg::OP_CHECK) ||
                        ((stage_op_ff == ptt_pkg::OP_SCAN) && stage_last_ff));
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign stage_stall = emits && !rsp_free;
   assign req_ready   = !clr_busy_ff && !stage_stall && !move_busy;
   assign req_fire    = req_valid && req_ready;
   assign wrap        = req_fire && (req_operation == ptt_pkg::OP_TICK) && (&count_ff);

   // pair status from the registered read
   assign limit   = SUM_BITS'(rd_stamp_ff[STAMP_BITS-1:0]) + SUM_BITS'(tenure_ff);
   assign tabu    = stage_ok && rd_stamp_ff[STAMP_BITS] && (SUM_BITS'(count_ff) <= limit);
   assign allowed = !tabu || (aspiration_ff && (stage_value_ff < rd_value_ff));
   assign hit     = stage_ok && (stage_group_ff != stage_other_ff) && allowed;

   // single write port per store
   always_comb begin
      st_we   = 1'b0;
      st_addr = req_cell;
      st_data = {1'b0, count_ff};
      va_we   = 1'b0;
      va_addr = req_cell;
      va_data = ptt_pkg::VALUE_MINUS_ONE;
      if (clr_busy_ff) begin
         st_we   = 1'b1;
         st_addr = clr_cnt_ff;
      end else if (move_busy) begin
         st_we   = other_ok;
         st_addr = other_cell;
         va_we   = other_ok;
         va_addr = other_cell;
      end else if (req_fire) begin
         case (req_operation)
            ptt_pkg::OP_ADD, ptt_pkg::OP_MOVE: begin
               st_we   = req_ok;
               st_data = {1'b1, count_ff};
               va_we   = req_ok && aspiration_ff;
               va_data = req_value;
            end
            ptt_pkg::OP_REMOVE: begin
               st_we = req_ok;
               va_we = req_ok;
            end
            default: begin
               st_we = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         stamp_mem_ff[st_addr] <= st_data;
      end
      if (va_we) begin
         value_mem_ff[va_addr] <= va_data;
      end
      if (req_fire) begin
         rd_stamp_ff <= stamp_mem_ff[req_cell];
         rd_value_ff <= value_mem_ff[req_cell];
      end
   end

   always_comb begin
      count_in      = count_ff;
      clr_busy_in   = clr_busy_ff;
      clr_cnt_in    = clr_cnt_ff;
      scan_found_in = scan_found_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == CELL_BITS'(CELLS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
      if (req_fire && (req_operation == ptt_pkg::OP_TICK)) begin
         count_in = count_ff + 1'b1;
         if (wrap) begin
            count_in    = '0;
            clr_busy_in = 1'b1;
            clr_cnt_in  = '0;
         end
      end
      if (stage_valid_ff && !stage_stall && (stage_op_ff == ptt_pkg::OP_SCAN)) begin
         scan_found_in = stage_last_ff ? 1'b0 : (scan_found_ff || hit);
      end
   end

   always_comb begin
      stage_valid_in  = req_fire ? 1'b1 : (stage_stall ? stage_valid_ff : 1'b0);
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kind_in     = rsp_kind_ff;
      rsp_tabu_in     = rsp_tabu_ff;
      rsp_allowed_in  = rsp_allowed_ff;
      rsp_reassign_in = rsp_reassign_ff;
      if (emits && rsp_free) begin
         rsp_valid_in = 1'b1;
         if (stage_op_ff == ptt_pkg::OP_CHECK) begin
            rsp_kind_in     = ptt_pkg::RESULT_CHECK;
            rsp_tabu_in     = tabu;
            rsp_allowed_in  = allowed;
            rsp_reassign_in = 1'b0;
         end else begin
            rsp_kind_in     = ptt_pkg::RESULT_SCAN;
            rsp_tabu_in     = 1'b0;
            rsp_allowed_in  = 1'b0;
            rsp_reassign_in = scan_found_ff || hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tenure_ff      <= ptt_pkg::TENURE_RESET;
         aspiration_ff  <= 1'b0;
         count_ff       <= '0;
         clr_busy_ff    <= 1'b1;
         clr_cnt_ff     <= '0;
         scan_found_ff  <= 1'b0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en && (csr_index == ptt_pkg::CSR_TENURE)) begin
            tenure_ff <= csr_wdata;
         end
         if (csr_wr_en && (csr_index == ptt_pkg::CSR_ASPIRATION)) begin
            aspiration_ff <= csr_wdata[0];
         end
         count_ff       <= count_in;
         clr_busy_ff    <= clr_busy_in;
         clr_cnt_ff     <= clr_cnt_in;
         scan_found_ff  <= scan_found_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_op_ff    <= req_operation;
         stage_item_ff  <= req_item_index;
         stage_group_ff <= req_group_index;
         stage_other_ff <= req_other_group;
         stage_value_ff <= req_value;
         stage_last_ff  <= req_last;
      end
      rsp_kind_ff     <= rsp_kind_in;
      rsp_tabu_ff     <= rsp_tabu_in;
      rsp_allowed_ff  <= rsp_allowed_in;
      rsp_reassign_ff <= rsp_reassign_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_tabu         = rsp_tabu_ff;
   assign rsp_allowed      = rsp_allowed_ff;
   assign rsp_reassignable = rsp_reassign_ff;

   // second write of a move blocks the next transfer
   a_move_gap: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_operation == ptt_pkg::OP_MOVE) |=> !req_fire)
      else $error("transfer during move write");

   // counter wrap starts a clearing pass
   a_wrap_clear: assert property (@(posedge clock) disable iff (reset)
      wrap |=> clr_busy_ff && (count_ff == '0))
      else $error("wrap did not start clearing");

   // a tabu-free check is always allowed
   a_check_allowed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == ptt_pkg::RESULT_CHECK) && !rsp_tabu |-> rsp_allowed)
      else $error("untabu pair not allowed");

   // scan results carry no check flags, check results no scan flag
   a_kind_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_result_kind == ptt_pkg::RESULT_SCAN) ?
                     (!rsp_tabu && !rsp_allowed) : !rsp_reassignable))
      else $error("result fields do not match kind");

endmodule

`default_nettype wire

// ===== test/pair_tabu_table_test.sv =====
// ----------------------------------------------------------------------------
// pair_tabu_table_test
// self-checking bench for the pair tabu table: a queue-fed driver and a
// monitor with random gaps and stalls, an in-bench copy of the table that
// predicts every check and scan answer, and phases over tenure and aspiration
// ----------------------------------------------------------------------------
`default_nettype none

module pair_tabu_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_BITS = ptt_pkg::OP_BITS;
   localparam int VALUE_BITS = ptt_pkg::VALUE_BITS;
   localparam int TENURE_BITS = ptt_pkg::TENURE_BITS;
   localparam int CSR_INDEX_BITS = ptt_pkg::CSR_INDEX_BITS;

   localparam int ITEMS = 64;
   localparam int GROUPS = 16;
   localparam int STAMP_BITS = 31;
   localparam int ITEM_BITS = 6;
   localparam int GROUP_BITS = 4;
   localparam int CELLS = ITEMS * GROUPS;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 175;
   localparam int MAX_IDLE = 14;
   localparam int SETTLE_CYCLES = 6;
   localparam int POOL_SIZE = 6;

   localparam logic [OP_BITS-1:0] OP_SPARE_A = 3'd6;
   localparam logic [OP_BITS-1:0] OP_SPARE_B = 3'd7;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [STAMP_BITS-1:0] COUNT_MAX = '1;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic [OP_BITS-1:0]           operation;
      logic [ITEM_BITS-1:0]         item;
      logic [GROUP_BITS-1:0]        group;
      logic [GROUP_BITS-1:0]        other;
      logic signed [VALUE_BITS-1:0] value;
      logic                         last;
   } tabu_req_type;

   typedef struct packed {
      logic kind;
      logic tabu;
      logic allowed;
      logic reassignable;
   } tabu_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [TENURE_BITS-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [OP_BITS-1:0] req_operation = ptt_pkg::OP_TICK;
   logic [ITEM_BITS-1:0] req_item_index = '0;
   logic [GROUP_BITS-1:0] req_group_index = '0;
   logic [GROUP_BITS-1:0] req_other_group = '0;
   logic signed [VALUE_BITS-1:0] req_value = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_result_kind;
   logic rsp_tabu;
   logic rsp_allowed;
   logic rsp_reassignable;

   // table copy used for prediction
   logic [TENURE_BITS-1:0] tenure_q = ptt_pkg::TENURE_RESET;
   logic aspiration_q = 1'b0;
   logic [STAMP_BITS-1:0] iter_count = '0;
   logic [STAMP_BITS-1:0] stamp_mem [CELLS];
   bit pair_live [CELLS];
   logic signed [VALUE_BITS-1:0] value_mem [CELLS];
   bit scan_hit = 1'b0;
   tabu_rsp_type answer_queue [$];

   // stimulus planning state
   tabu_req_type send_queue [$];
   int unsent = 0;
   bit plan_aspiration = 1'b0;
   bit plan_live [CELLS];
   bit plan_written [CELLS];
   logic signed [VALUE_BITS-1:0] value_pool [POOL_SIZE];

   tabu_req_type on_bus;
   int send_gap = 0;
   int recv_gap = 0;
   bit send_burst = 1'b0;
   bit recv_burst = 1'b0;
   logic req_take;
   logic rsp_take;
   tabu_rsp_type want;
   int errors = 0;

   pair_tabu_table #(
      .ITEMS(ITEMS),
      .GROUPS(GROUPS),
      .STAMP_BITS(STAMP_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_item_index(req_item_index),
      .req_group_index(req_group_index),
      .req_other_group(req_other_group),
      .req_value(req_value),
      .req_last(req_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_kind(rsp_result_kind),
      .rsp_tabu(rsp_tabu),
      .rsp_allowed(rsp_allowed),
      .rsp_reassignable(rsp_reassignable)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int cell_of(logic [ITEM_BITS-1:0] item, logic [GROUP_BITS-1:0] group);
      return int'({item, group});
   endfunction

   function automatic bit pair_tabu(int c);
      return pair_live[c] &&
             (longint'(iter_count) <= longint'(stamp_mem[c]) + longint'(tenure_q));
   endfunction

   function automatic bit pair_allowed(int c, logic signed [VALUE_BITS-1:0] v);
      return !pair_tabu(c) || (aspiration_q && v < value_mem[c]);
   endfunction

   function automatic void add_pair(int c, logic signed [VALUE_BITS-1:0] v);
      stamp_mem[c] = iter_count;
      pair_live[c] = 1'b1;
      if (aspiration_q) value_mem[c] = v;
   endfunction

   function automatic void drop_pair(int c);
      pair_live[c] = 1'b0;
      value_mem[c] = ptt_pkg::VALUE_MINUS_ONE;
   endfunction

   // applies one accepted transfer to the table copy, queues any answer
   function automatic void advance_table(tabu_req_type r);
      tabu_rsp_type ans;
      int c;
      c = cell_of(r.item, r.group);
      ans = '0;
      case (r.operation)
         ptt_pkg::OP_TICK: begin
            if (iter_count == COUNT_MAX) begin
               iter_count = '0;
               foreach (pair_live[i]) pair_live[i] = 1'b0;
            end else begin
               iter_count = iter_count + 1'b1;
            end
         end
         ptt_pkg::OP_ADD: add_pair(c, r.value);
         ptt_pkg::OP_REMOVE: drop_pair(c);
         ptt_pkg::OP_MOVE: begin
            add_pair(c, r.value);
            drop_pair(cell_of(r.item, r.other));
         end
         ptt_pkg::OP_CHECK: begin
            ans.kind = ptt_pkg::RESULT_CHECK;
            ans.tabu = pair_tabu(c);
            ans.allowed = pair_allowed(c, r.value);
            answer_queue.push_back(ans);
         end
         ptt_pkg::OP_SCAN: begin
            if (r.group != r.other && pair_allowed(c, r.value)) scan_hit = 1'b1;
            if (r.last) begin
               ans.kind = ptt_pkg::RESULT_SCAN;
               ans.reassignable = scan_hit;
               answer_queue.push_back(ans);
               scan_hit = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic int draw_idle(inout bit burst);
      if ($urandom_range(0, 31) == 0) burst = !burst;
      return burst ? 0 : $urandom_range(0, MAX_IDLE);
   endfunction

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, POOL_SIZE - 1)];
      return VALUE_BITS'($urandom);
   endfunction

   function automatic tabu_req_type req_of(logic [OP_BITS-1:0] op, int item, int group,
                                           int other, logic signed [VALUE_BITS-1:0] v,
                                           logic last);
      tabu_req_type r;
      r.operation = op;
      r.item = ITEM_BITS'(item);
      r.group = GROUP_BITS'(group);
      r.other = GROUP_BITS'(other);
      r.value = v;
      r.last = last;
      return r;
   endfunction

   // most traffic goes to a few rows so that checks and scans meet stored pairs
   function automatic tabu_req_type make_req(logic [OP_BITS-1:0] op);
      int item;
      item = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, ITEMS - 1);
      return req_of(op, item, $urandom_range(0, GROUPS - 1), $urandom_range(0, GROUPS - 1),
                    pick_value(), 1'b0);
   endfunction

   // queues one item; checks and scans of live unwritten pairs get an add first
   function automatic void plan(tabu_req_type r);
      tabu_req_type guard;
      int c;
      c = cell_of(r.item, r.group);
      if ((r.operation == ptt_pkg::OP_CHECK || r.operation == ptt_pkg::OP_SCAN) &&
          plan_aspiration && plan_live[c] && !plan_written[c]) begin
         guard = r;
         guard.operation = ptt_pkg::OP_ADD;
         guard.last = 1'b0;
         send_queue.push_back(guard);
         unsent++;
         plan_written[c] = 1'b1;
      end
      case (r.operation)
         ptt_pkg::OP_ADD, ptt_pkg::OP_MOVE: begin
            plan_live[c] = 1'b1;
            plan_written[c] = plan_written[c] | plan_aspiration;
            if (r.operation == ptt_pkg::OP_MOVE) begin
               plan_live[cell_of(r.item, r.other)] = 1'b0;
               plan_written[cell_of(r.item, r.other)] = 1'b1;
            end
         end
         ptt_pkg::OP_REMOVE: begin
            plan_live[c] = 1'b0;
            plan_written[c] = 1'b1;
         end
         default: ;
      endcase
      send_queue.push_back(r);
      unsent++;
   endfunction

   function automatic void plan_random(int n);
      tabu_req_type r;
      int made;
      int pick;
      int len;
      int ticks;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // scan of one item, full sweep or a few groups
            r = make_req(ptt_pkg::OP_SCAN);
            len = ($urandom_range(0, 1) != 0) ? GROUPS : $urandom_range(1, 6);
            for (int g = 0; g < len; g++) begin
               r.group = (len == GROUPS) ? GROUP_BITS'(g) : GROUP_BITS'($urandom);
               r.value = pick_value();
               r.last = (g == len - 1);
               plan(r);
            end
            made += len;
         end else if (pick < 30) begin
            plan(make_req(($urandom_range(0, 1) != 0) ? ptt_pkg::OP_ADD : ptt_pkg::OP_MOVE));
            made++;
         end else if (pick < 40) begin
            plan(make_req(ptt_pkg::OP_REMOVE));
            made++;
         end else if (pick < 58) begin
            ticks = $urandom_range(1, 3);
            repeat (ticks) plan(make_req(ptt_pkg::OP_TICK));
            made += ticks;
         end else if (pick < 85) begin
            plan(make_req(ptt_pkg::OP_CHECK));
            made++;
         end else if (pick < 92) begin
            // stray scan element that runs into the next scan
            plan(make_req(ptt_pkg::OP_SCAN));
            made++;
         end else begin
            r = make_req(OP_BITS'($urandom));
            r.item = ITEM_BITS'($urandom);
            r.last = 1'($urandom);
            plan(r);
            if (r.operation <= ptt_pkg::OP_SCAN) made++;
         end
      end
   endfunction

   task automatic write_csr(logic [CSR_INDEX_BITS-1:0] idx, logic [TENURE_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == ptt_pkg::CSR_TENURE) tenure_q = data;
      else if (idx == ptt_pkg::CSR_ASPIRATION) aspiration_q = data[0];
   endtask

   task automatic drain();
      do @(posedge clock); while (unsent != 0 || answer_queue.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void compare_field(string name, logic expected, logic actual);
      if (actual !== expected) begin
         $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, expected,
                  actual);
         errors++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      req_take = req_valid && req_ready;
      if (req_take) begin
         advance_table(on_bus);
         unsent--;
      end
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_take) begin
         if (send_gap > 0 || send_queue.size() == 0) begin
            if (send_gap > 0) send_gap--;
            req_valid <= 1'b0;
         end else begin
            on_bus = send_queue.pop_front();
            req_valid <= 1'b1;
            req_operation <= on_bus.operation;
            req_item_index <= on_bus.item;
            req_group_index <= on_bus.group;
            req_other_group <= on_bus.other;
            req_value <= on_bus.value;
            req_last <= on_bus.last;
            send_gap = draw_idle(send_burst);
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_take = rsp_valid && rsp_ready;
      if (rsp_take) begin
         if (answer_queue.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual kind %0b", $time,
                     rsp_result_kind);
            errors++;
         end else begin
            want = answer_queue.pop_front();
            compare_field("result_kind", want.kind, rsp_result_kind);
            compare_field("tabu", want.tabu, rsp_tabu);
            compare_field("allowed", want.allowed, rsp_allowed);
            compare_field("reassignable", want.reassignable, rsp_reassignable);
         end
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_take || !rsp_ready) begin
         if (rsp_take) recv_gap = draw_idle(recv_burst);
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [TENURE_BITS-1:0] tn;
      bit asp;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         tn = ptt_pkg::TENURE_RESET;
         asp = 1'b0;
         case (p)
            1: begin tn = 16'd0; asp = 1'b1; end
            2: begin tn = 16'hFFFF; asp = 1'b1; end
            3: begin tn = 16'd3; asp = 1'b0; end
            4: begin tn = 16'd1; asp = 1'b1; end
            5: begin tn = TENURE_BITS'($urandom_range(0, 20)); asp = 1'b1; end
            6: begin tn = 16'hFFFF; asp = 1'b0; end
            7: begin tn = TENURE_BITS'($urandom); asp = 1'($urandom); end
            default: ;
         endcase
         if (p != 0) begin
            drain();
            write_csr(ptt_pkg::CSR_TENURE, tn);
            write_csr(ptt_pkg::CSR_ASPIRATION, {15'($urandom), asp});
            if (p == 1) begin
               write_csr(CSR_SPARE_A, TENURE_BITS'($urandom));
               write_csr(CSR_SPARE_B, TENURE_BITS'($urandom));
            end
         end
         plan_aspiration = asp;
         value_pool = '{VALUE_MIN, VALUE_MAX, ptt_pkg::VALUE_MINUS_ONE, '0,
                        VALUE_BITS'($urandom), VALUE_BITS'($urandom)};
         if (p == 0) begin
            // fresh pair, tenure expiry, remove, move, scans, unused codes
            plan(req_of(ptt_pkg::OP_CHECK, 0, 0, 0, VALUE_MIN, 1'b0));
            plan(req_of(ptt_pkg::OP_ADD, 0, 0, 0, VALUE_MAX, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 0, 0, 0, VALUE_MAX, 1'b0));
            repeat (7) plan(req_of(ptt_pkg::OP_TICK, 0, 0, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 0, 0, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_TICK, 0, 0, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 0, 0, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_ADD, 63, 15, 15, VALUE_MAX, 1'b1));
            plan(req_of(ptt_pkg::OP_REMOVE, 63, 15, 0, VALUE_MAX, 1'b1));
            plan(req_of(ptt_pkg::OP_CHECK, 63, 15, 15, VALUE_MIN, 1'b1));
            plan(req_of(ptt_pkg::OP_MOVE, 1, 2, 5, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 1, 2, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_MOVE, 2, 3, 3, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 2, 3, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_SCAN, 1, 2, 2, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_SCAN, 1, 0, 2, '0, 1'b1));
            plan(req_of(ptt_pkg::OP_ADD, 3, 0, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_SCAN, 3, 0, 1, '0, 1'b1));
            plan(req_of(OP_SPARE_A, 5, 5, 5, VALUE_MIN, 1'b1));
            plan(req_of(OP_SPARE_B, 5, 5, 5, VALUE_MAX, 1'b1));
         end else if (p == 1) begin
            // aspiration: strictly lower value passes, equal and higher do not
            plan(req_of(ptt_pkg::OP_ADD, 0, 4, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 0, 4, 0, ptt_pkg::VALUE_MINUS_ONE, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 0, 4, 0, '0, 1'b0));
            plan(req_of(ptt_pkg::OP_CHECK, 0, 4, 0, VALUE_MAX, 1'b0));
         end
         plan_random(PHASE_ITEMS);
      end
      drain();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ===== pair_tabu_table.f =====
rtl/ptt_pkg.sv
rtl/pair_tabu_table.sv
test/pair_tabu_table_test.sv
